[src/dbe_pkg.sv]
// Package for the key and encoder debouncer: channel codes, constants and the
// structs passed between the lanes, the merging stage and the top level.
// No dependencies.
package dbe_pkg;

    localparam int NUM_KEYS_DEF = 3;
    localparam int TIME_W       = 48;
    localparam int UNIT_SHIFT   = 10;
    localparam int ELAPSED_W    = 32;
    localparam int COUNT_W      = 16;
    localparam int THR_W        = 8;
    localparam int OUT_BITS     = 5;
    localparam int CHI_W        = 3;

    localparam logic [COUNT_W-1:0] HOME_COUNT    = 16'd32768;
    localparam logic [THR_W-1:0]   KEY_THR_RESET = 8'd8;
    localparam logic [THR_W-1:0]   ROT_THR_RESET = 8'd13;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_GROUP  = 2'd1,
        KIND_SINGLE = 2'd2,
        KIND_HOLD   = 2'd3
    } kind_t;

    typedef enum logic {
        REG_KEY_THR = 1'b0,
        REG_ROT_THR = 1'b1
    } reg_index_t;

    // Per-item control shared by every lane.
    typedef struct packed {
        logic tick;
        logic group_q;
        logic single_q;
        logic wanted;
    } lane_ctrl_t;

    // What one lane reports for the item in flight.
    typedef struct packed {
        logic state;
        logic consumed;
        logic fired;
    } lane_stat_t;

    typedef struct packed {
        logic [OUT_BITS-1:0]  state_bits;
        logic [OUT_BITS-1:0]  event_bits;
        logic                 event_hit;
        logic                 held_long;
        logic [ELAPSED_W-1:0] elapsed_units;
        logic                 encoder_reload;
    } result_t;

endpackage

[src/dbe_lane.sv]
// One debounce channel: integrating counter, debounced state, pending event
// and change timestamp. Depends on dbe_pkg.
module dbe_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  dbe_pkg::lane_ctrl_t          ctrl,
    input  logic                         rotation,
    input  logic                         active,
    input  logic                         selected,
    input  logic [dbe_pkg::THR_W-1:0]    threshold,
    input  logic [dbe_pkg::TIME_W-1:0]   now,
    output dbe_pkg::lane_stat_t          stat,
    output logic                         state,
    output logic [dbe_pkg::TIME_W-1:0]   stamp
);
    import dbe_pkg::*;

    logic [THR_W-1:0]  integ_reg,   integ_next;
    logic              state_reg,   state_next;
    logic              pending_reg, pending_next;
    logic [TIME_W-1:0] stamp_reg,   stamp_next;
    logic [THR_W-1:0]  climbed;
    logic              set_change;
    logic              set_value;

    always_comb
    begin
        integ_next   = integ_reg;
        state_next   = state_reg;
        pending_next = pending_reg;
        stamp_next   = stamp_reg;
        set_change   = 1'b0;
        set_value    = 1'b0;
        stat.fired    = 1'b0;
        stat.consumed = 1'b0;
        climbed      = (integ_reg < threshold) ? integ_reg + 8'd1 : integ_reg;

        if (ctrl.tick)
        begin
            if (active)
            begin
                if (rotation)
                begin
                    // A rotation channel saturates and fires again on every tick.
                    integ_next = climbed;
                    if (climbed == threshold)
                    begin
                        set_change = 1'b1;
                        set_value  = 1'b1;
                        stat.fired = 1'b1;
                    end
                end
                else if (integ_reg < threshold)
                begin
                    integ_next = climbed;
                    if (climbed == threshold)
                    begin
                        set_change = 1'b1;
                        set_value  = 1'b1;
                    end
                end
            end
            else if (integ_reg != '0)
            begin
                integ_next = integ_reg - 8'd1;
                if (integ_reg == 8'd1)
                begin
                    set_change = 1'b1;
                    stat.fired = rotation;
                end
            end
        end

        if ((ctrl.group_q || (ctrl.single_q && selected)) && pending_reg
            && (state_reg == ctrl.wanted))
        begin
            pending_next  = 1'b0;
            stat.consumed = 1'b1;
        end

        if (set_change)
        begin
            state_next   = set_value;
            pending_next = 1'b1;
            stamp_next   = now;
        end

        stat.state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg   <= '0;
            state_reg   <= 1'b0;
            pending_reg <= 1'b0;
            stamp_reg   <= '0;
        end
        else if (accept)
        begin
            integ_reg   <= integ_next;
            state_reg   <= state_next;
            pending_reg <= pending_next;
            stamp_reg   <= stamp_next;
        end
    end

    assign state = state_reg;
    assign stamp = stamp_reg;

endmodule

[src/dbe_merge.sv]
// Merging stage: gathers the lane reports into one result, selects the asked
// channel's timestamp and runs the hold test. Depends on dbe_pkg.
module dbe_merge #(
    parameter int NUM_CH = dbe_pkg::NUM_KEYS_DEF + 2,
    parameter int NUM_KEYS = dbe_pkg::NUM_KEYS_DEF
) (
    input  dbe_pkg::lane_stat_t            stat [NUM_CH],
    input  logic [NUM_CH-1:0]              cur_state,
    input  logic [dbe_pkg::TIME_W-1:0]     stamp [NUM_CH],
    input  dbe_pkg::kind_t                 kind,
    input  logic [dbe_pkg::CHI_W-1:0]      channel_index,
    input  logic                           wanted,
    input  logic [dbe_pkg::TIME_W-1:0]     now,
    input  logic [dbe_pkg::ELAPSED_W-1:0]  hold_time,
    output dbe_pkg::result_t               result
);
    import dbe_pkg::*;

    localparam int WORD_W = (NUM_CH > OUT_BITS) ? NUM_CH : OUT_BITS;

    logic [WORD_W-1:0]    state_word;
    logic [WORD_W-1:0]    event_word;
    logic [NUM_CH-1:0]    consumed;
    logic                 fired_any;
    logic                 in_range;
    logic                 sel_state;
    logic [TIME_W-1:0]    sel_stamp;
    logic [TIME_W-1:0]    diff;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 query;

    always_comb
    begin
        state_word = '0;
        event_word = '0;
        consumed   = '0;
        fired_any  = 1'b0;
        in_range   = 1'b0;
        sel_state  = 1'b0;
        sel_stamp  = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            state_word[ch] = stat[ch].state;
            consumed[ch]   = stat[ch].consumed;
            if (ch >= NUM_KEYS)
                fired_any = fired_any | stat[ch].fired;
            if (32'(channel_index) == ch)
            begin
                in_range  = 1'b1;
                sel_state = cur_state[ch];
                sel_stamp = stamp[ch];
            end
        end
        event_word[NUM_CH-1:0] = (kind == KIND_GROUP) ? consumed : '0;

        // The time difference wraps modulo the width of the tick count.
        diff    = now - sel_stamp;
        elapsed = diff[UNIT_SHIFT +: ELAPSED_W];
        query   = ((kind == KIND_SINGLE) || (kind == KIND_HOLD)) && in_range;

        result.state_bits     = state_word[OUT_BITS-1:0];
        result.event_bits     = event_word[OUT_BITS-1:0];
        result.event_hit      = (kind == KIND_SINGLE) && (|consumed);
        result.held_long      = (kind == KIND_HOLD) && in_range
                                && (sel_state == wanted) && (elapsed >= hold_time);
        result.elapsed_units  = query ? elapsed : '0;
        result.encoder_reload = (kind == KIND_TICK) && fired_any;
    end

endmodule

[src/debounce_buttons_encoder.sv]
// Top level of the key and encoder debouncer: configuration registers, one
// lane per channel, the merging stage and a two-entry output buffer.
// Depends on dbe_pkg, dbe_lane and dbe_merge.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | kind, key_levels, encoder_count, time_now,
//          |                      | channel_index, wanted_state, hold_time
//  output  | out_valid / out_stall| state_bits, event_bits, event_hit,
//          |                      | held_long, elapsed_units, encoder_reload
//  config  | cfg_write            | cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; its result is registered.
// All channels update side by side in their own lanes, so the rate is set only
// by the output buffer, which holds up to two results.
// Reset clears all counters, states, events and timestamps and loads the
// default thresholds. in_stall rises only when both buffer entries are full.
module debounce_buttons_encoder #(
    parameter int NUM_KEYS = dbe_pkg::NUM_KEYS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic [NUM_KEYS-1:0]               key_levels,
    input  logic [dbe_pkg::COUNT_W-1:0]       encoder_count,
    input  logic [dbe_pkg::TIME_W-1:0]        time_now,
    input  logic [dbe_pkg::CHI_W-1:0]         channel_index,
    input  logic                              wanted_state,
    input  logic [dbe_pkg::ELAPSED_W-1:0]     hold_time,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dbe_pkg::OUT_BITS-1:0]      state_bits,
    output logic [dbe_pkg::OUT_BITS-1:0]      event_bits,
    output logic                              event_hit,
    output logic                              held_long,
    output logic [dbe_pkg::ELAPSED_W-1:0]     elapsed_units,
    output logic                              encoder_reload,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [dbe_pkg::THR_W-1:0]         cfg_data
);
    import dbe_pkg::*;

    localparam int NUM_CH = NUM_KEYS + 2;

    logic [THR_W-1:0] key_thr_reg;
    logic [THR_W-1:0] rot_thr_reg;

    logic              accept;
    kind_t             kind_in;
    lane_ctrl_t        ctrl;
    lane_stat_t        stat [NUM_CH];
    logic [NUM_CH-1:0] cur_state;
    logic [TIME_W-1:0] stamp [NUM_CH];
    result_t           new_result;

    result_t main_reg,  main_next;
    result_t skid_reg,  skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    out_take;

    assign kind_in       = kind_t'(kind);
    assign accept        = in_valid && !in_stall;
    assign ctrl.tick     = (kind_in == KIND_TICK);
    assign ctrl.group_q  = (kind_in == KIND_GROUP);
    assign ctrl.single_q = (kind_in == KIND_SINGLE);
    assign ctrl.wanted   = wanted_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_thr_reg <= KEY_THR_RESET;
            rot_thr_reg <= ROT_THR_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_KEY_THR: key_thr_reg <= cfg_data;
                REG_ROT_THR: rot_thr_reg <= cfg_data;
                default:     key_thr_reg <= key_thr_reg;
            endcase
        end
    end

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        logic is_rot;
        logic active;

        assign is_rot = (ch >= NUM_KEYS);
        if (ch < NUM_KEYS)
        begin : g_key
            assign active = !key_levels[ch];
        end
        else if (ch == NUM_KEYS)
        begin : g_up
            assign active = (encoder_count < HOME_COUNT);
        end
        else
        begin : g_down
            assign active = (encoder_count > HOME_COUNT);
        end

        dbe_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (accept),
            .ctrl      (ctrl),
            .rotation  (is_rot),
            .active    (active),
            .selected  (32'(channel_index) == ch),
            .threshold (is_rot ? rot_thr_reg : key_thr_reg),
            .now       (time_now),
            .stat      (stat[ch]),
            .state     (cur_state[ch]),
            .stamp     (stamp[ch])
        );
    end

    dbe_merge #(
        .NUM_CH   (NUM_CH),
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .stat          (stat),
        .cur_state     (cur_state),
        .stamp         (stamp),
        .kind          (kind_in),
        .channel_index (channel_index),
        .wanted        (wanted_state),
        .now           (time_now),
        .hold_time     (hold_time),
        .result        (new_result)
    );

    // Output buffer: the skid entry takes a result while the main one is stalled.
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next      = new_result;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_next       = new_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign state_bits     = main_reg.state_bits;
    assign event_bits     = main_reg.event_bits;
    assign event_hit      = main_reg.event_hit;
    assign held_long      = main_reg.held_long;
    assign elapsed_units  = main_reg.elapsed_units;
    assign encoder_reload = main_reg.encoder_reload;

    // The skid entry is only ever filled behind a waiting main entry.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !skid_valid_reg)
        else $error("skid entry full while output entry empty");

    // A transfer into an empty buffer shows a result in the next cycle.
    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !out_valid_reg) |=> out_valid)
        else $error("accepted item produced no result");

    // A waiting skid entry moves forward as soon as the main entry leaves.
    a_skid_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && skid_valid_reg) |=> (out_valid && !skid_valid_reg))
        else $error("skid entry not moved forward");

endmodule
